### design/safs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared constants, result codes and the control/status structures that pass
// between the controller and the datapath of the slot allocator.
// ----------------------------------------------------------------------------
package safs_pkg;

    // Default pool size.
    localparam int SLOTS_DEF = 64;

    // Field widths of the stream words.
    localparam int CMD_W    = 1;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 8;

    // Width of one group of used bits examined by the search.
    localparam int GRP_W  = 32;
    localparam int GRP_IW = 5;

    // Request kinds.
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    // Result codes.
    localparam logic [STATUS_W-1:0] RES_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] RES_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] RES_OVFL = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the incoming request
        logic search;  // read the stack top and search the used bits
        logic commit;  // update the state and post the result
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;  // result register full and not taken this cycle
    } t_dp_status;

endpackage

### design/safs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator controller
// Sequences each request through capture, search and commit, and decides when
// a new request may be taken.
// ----------------------------------------------------------------------------
module safs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  safs_pkg::t_dp_status  i_status,
    output safs_pkg::t_ctl_cmd    o_cmd
);
    import safs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SRCH = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_commit;
    logic       w_accept;

    // A request may be taken when idle, or when the current one commits.
    assign w_commit   = (r_state == S_DONE) && !i_status.out_busy;
    assign o_in_ready = (r_state == S_IDLE) || w_commit;
    assign w_accept   = i_in_valid && o_in_ready;

    assign o_cmd.load   = w_accept;
    assign o_cmd.search = (r_state == S_SRCH);
    assign o_cmd.commit = w_commit;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_SRCH;
            end
            S_SRCH: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_commit) n_state = w_accept ? S_SRCH : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### design/safs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator datapath
// Holds the used bits, the free stack memory and its count, the search for
// the lowest unused slot and the result register.
// ----------------------------------------------------------------------------
module safs_datapath #(
    parameter int SLOTS = safs_pkg::SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  safs_pkg::t_ctl_cmd             i_cmd,
    output safs_pkg::t_dp_status           o_status,
    input  logic [safs_pkg::CMD_W-1:0]     i_req_cmd,
    input  logic [safs_pkg::SLOT_W-1:0]    i_req_slot,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [safs_pkg::STATUS_W-1:0]  o_out_status,
    output logic [safs_pkg::SLOT_W-1:0]    o_out_slot
);
    import safs_pkg::*;

    localparam int SW  = $clog2(SLOTS);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int NG  = (SLOTS + GRP_W - 1) / GRP_W;
    localparam int GIW = (NG > 1) ? $clog2(NG) : 1;
    localparam int PW  = GIW + GRP_IW;

    // Request registers.
    logic [CMD_W-1:0]  r_cmd;
    logic [SLOT_W-1:0] r_slot;

    // State.
    logic [SLOTS-1:0]  r_used;
    logic [CW-1:0]     r_count;
    logic [SW-1:0]     r_stack [SLOTS];

    // Search and read results.
    logic [SW-1:0]     r_rd_data;
    logic [GIW-1:0]    r_grp_idx;
    logic              r_grp_any;
    logic [GRP_W-1:0]  r_grp_word;

    // Result register.
    logic              r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SLOT_W-1:0] r_out_slot;

    // Combinational signals.
    logic [NG*GRP_W-1:0] w_used_pad;
    logic [GRP_W-1:0]    w_grp_word [NG];
    logic [GIW-1:0]      w_first_grp;
    logic                w_any_grp;
    logic [GRP_IW-1:0]   w_bit_idx;
    logic [PW-1:0]       w_pick_full;
    logic [SW-1:0]       w_pick;
    logic                w_pop;
    logic                w_alloc_ok;
    logic                w_in_pool;
    logic                w_free_ok;
    logic [SW-1:0]       w_free_idx;
    logic [CW-1:0]       w_top;
    logic [STATUS_W-1:0] w_res_status;
    logic [SLOT_W-1:0]   w_res_slot;

    // Slots beyond the pool read as used, so the search never picks them.
    always_comb begin
        for (int i = 0; i < NG * GRP_W; i++) begin
            w_used_pad[i] = (i < SLOTS) ? r_used[i] : 1'b1;
        end
        for (int g = 0; g < NG; g++) begin
            w_grp_word[g] = w_used_pad[g*GRP_W +: GRP_W];
        end
    end

    // First group that still has an unused slot.
    always_comb begin
        w_first_grp = '0;
        w_any_grp   = 1'b0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (!(&w_grp_word[g])) begin
                w_first_grp = GIW'(g);
                w_any_grp   = 1'b1;
            end
        end
    end

    // Lowest unused bit inside the chosen group.
    always_comb begin
        w_bit_idx = '0;
        for (int b = GRP_W - 1; b >= 0; b--) begin
            if (!r_grp_word[b]) w_bit_idx = GRP_IW'(b);
        end
    end

    // The stack top is the count less one.
    assign w_top = r_count - CW'(1);

    // Search stage: read the stack top and pick the group.
    always_ff @(posedge i_clk) begin
        if (i_cmd.search) begin
            r_rd_data  <= r_stack[w_top[SW-1:0]];
            r_grp_idx  <= w_first_grp;
            r_grp_any  <= w_any_grp;
            r_grp_word <= w_grp_word[w_first_grp];
        end
    end

    // Decisions for the commit stage.
    assign w_pop       = (r_count != '0);
    assign w_pick_full = {r_grp_idx, w_bit_idx};
    assign w_pick      = w_pop ? r_rd_data : w_pick_full[SW-1:0];
    assign w_alloc_ok  = w_pop || r_grp_any;
    assign w_in_pool   = (int'(r_slot) < SLOTS);
    assign w_free_ok   = w_in_pool && (int'(r_count) < SLOTS);
    assign w_free_idx  = SW'(r_slot);

    // Result of the current request.
    always_comb begin
        w_res_status = RES_OK;
        w_res_slot   = '0;
        if (r_cmd == CMD_ALLOC) begin
            if (w_alloc_ok) begin
                w_res_slot = SLOT_W'(w_pick);
            end else begin
                w_res_status = RES_FULL;
            end
        end else if (w_in_pool && !w_free_ok) begin
            w_res_status = RES_OVFL;
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_req_cmd;
            r_slot <= i_req_slot;
        end
    end

    // Stack memory write on a successful free.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_cmd == CMD_FREE) && w_free_ok) begin
            r_stack[r_count[SW-1:0]] <= w_free_idx;
        end
    end

    // Used bits and stack count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= '0;
        end else if (i_cmd.commit) begin
            if (r_cmd == CMD_ALLOC) begin
                if (w_alloc_ok) r_used[w_pick] <= 1'b1;
                if (w_pop) r_count <= w_top;
            end else if (w_free_ok) begin
                r_used[w_free_idx] <= 1'b0;
                r_count            <= r_count + CW'(1);
            end
        end
    end

    // Result register, which holds a word until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= w_res_status;
            r_out_slot   <= w_res_slot;
        end
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_status      = r_out_status;
    assign o_out_slot        = r_out_slot;

endmodule

### design/slot_allocator_free_stack_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator with free stack
//
//   Channel  Dir  tdata (low bit up)         tuser
//   s_axis   in   slot_in[5:0], pad[7:6]     cmd (0 allocate, 1 free)
//   m_axis   out  slot_out[5:0], pad[7:6]    status[1:0]
//
// Each request gives one result word. It is captured; the search reads the
// stack top and finds the first group with an unused slot; the commit picks
// the slot, updates the state and loads the result register. A new request is
// taken in the cycle that the previous one commits. Reset clears the used bits,
// the stack count and the result register at once. While the result register
// is full and not taken, the commit waits, and a request is taken only if idle.
// ----------------------------------------------------------------------------
module slot_allocator_free_stack_top #(
    parameter int SLOTS = safs_pkg::SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [5:0] slot_in, [7:6] zero
    input  logic [0:0] s_axis_tuser,   // [0] cmd
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [5:0] slot_out, [7:6] zero
    output logic [1:0] m_axis_tuser    // [1:0] status
);
    import safs_pkg::*;

    t_ctl_cmd          w_cmd;
    t_dp_status        w_status;
    logic [SLOT_W-1:0] w_out_slot;

    // Controller.
    safs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    safs_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_req_cmd    (s_axis_tuser),
        .i_req_slot   (s_axis_tdata[SLOT_W-1:0]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_status (m_axis_tuser),
        .o_out_slot   (w_out_slot)
    );

    assign m_axis_tdata = {(DATA_W - SLOT_W)'(0), w_out_slot};

endmodule
